// ===== src/assert_macros.svh =====
// Concurrent assertion helpers, clocked on rising edge, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pcfe_pkg.sv =====
`timescale 1ns / 1ps
package pcfe_pkg;

    localparam int IFACE_DEPTH = 16;
    localparam int IFACE_AW    = (IFACE_DEPTH > 1) ? $clog2(IFACE_DEPTH) : 1;
    localparam int IFACE_CW    = $clog2(IFACE_DEPTH + 1);

    localparam logic [31:0] BT_SHB = 32'h0A0D0D0A;
    localparam logic [31:0] BT_IDB = 32'h00000001;
    localparam logic [31:0] BT_EPB = 32'h00000006;

    localparam logic [31:0] LT_ETH  = 32'd1;
    localparam logic [31:0] LT_CAN  = 32'd227;
    localparam logic [31:0] LT_LIN  = 32'd254;
    localparam logic [31:0] LT_FLEX = 32'd259;

    localparam int HEAD_N = 14;

    typedef enum logic [2:0] {
        PH_TYPE, PH_LEN, PH_BODY, PH_TRAIL, PH_HALT
    } t_phase;

    typedef enum logic [1:0] {
        K_DATA   = 2'd0,
        K_COMMIT = 2'd1,
        K_CANCEL = 2'd2,
        K_ERROR  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        B_CAN   = 3'd0,
        B_CANFD = 3'd1,
        B_LIN   = 3'd2,
        B_ETH   = 3'd3,
        B_FLEX  = 3'd4
    } t_bus;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        t_bus        bus_kind;
        logic [63:0] timestamp_ns;
        logic [28:0] frame_id;
        logic [7:0]  frame_length;
        logic        fr_channel;
        logic [5:0]  fr_cycle;
        logic        fr_static;
    } t_result;

endpackage

// ===== src/pcapng_bus_frame_extractor_top.sv =====
`timescale 1ns / 1ps
// Byte-serial pcapng parser: takes one capture byte per cycle unless stalled, and
// gives at most one result per byte (a data byte, a frame descriptor, a cancel or
// an error) through a registered two-entry output buffer. The interface link
// type table sits in a single-port-write, registered-read RAM; its lookup for a
// packet is issued on the last interface-id byte and lands before the link type
// is needed. Input stalls only when both output entries are full.
module pcapng_bus_frame_extractor_top
    import pcfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [2:0]  o_bus_kind,
    output logic [63:0] o_timestamp_ns,
    output logic [28:0] o_frame_id,
    output logic [7:0]  o_frame_length,
    output logic        o_fr_channel,
    output logic [5:0]  o_fr_cycle,
    output logic        o_fr_static
);
`include "assert_macros.svh"

    logic                take;
    logic                tbl_we;
    logic [IFACE_AW-1:0] tbl_waddr, tbl_raddr;
    logic [31:0]         tbl_wdata, tbl_rdata;
    logic                res_valid;
    t_result             res;

    logic    r_v0, r_v1;
    t_result r_d0, r_d1;
    logic    pop;

    assign o_stall = r_v1;
    assign take    = i_valid && !r_v1;
    assign pop     = r_v0 && !i_stall;

    pcfe_ram #(
        .WIDTH(32),
        .DEPTH(IFACE_DEPTH)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    pcfe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_action    (i_action),
        .i_in_byte   (i_in_byte),
        .o_tbl_we    (tbl_we),
        .o_tbl_waddr (tbl_waddr),
        .o_tbl_wdata (tbl_wdata),
        .o_tbl_raddr (tbl_raddr),
        .i_tbl_rdata (tbl_rdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Two-entry output buffer: head drives the ports, second entry absorbs a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (pop) begin
            if (r_v1) begin
                r_v0 <= 1'b1;
                r_v1 <= res_valid;
            end else begin
                r_v0 <= res_valid;
            end
        end else if (!r_v0) begin
            r_v0 <= res_valid;
        end else if (res_valid) begin
            r_v1 <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_v1) begin
                r_d0 <= r_d1;
                r_d1 <= res;
            end else begin
                r_d0 <= res;
            end
        end else if (!r_v0) begin
            r_d0 <= res;
        end else if (res_valid) begin
            r_d1 <= res;
        end
    end

    assign o_valid        = r_v0;
    assign o_kind         = r_d0.kind;
    assign o_data_byte    = r_d0.data_byte;
    assign o_bus_kind     = r_d0.bus_kind;
    assign o_timestamp_ns = r_d0.timestamp_ns;
    assign o_frame_id     = r_d0.frame_id;
    assign o_frame_length = r_d0.frame_length;
    assign o_fr_channel   = r_d0.fr_channel;
    assign o_fr_cycle     = r_d0.fr_cycle;
    assign o_fr_static    = r_d0.fr_static;

    `CHK_SAME(a_buf_order, i_clk, i_rst_n, r_v1, r_v0, "second entry without head")
    `CHK_NEXT(a_buf_hold, i_clk, i_rst_n, r_v1 && i_stall, r_v1 && r_v0, "buffer lost a request")
    `CHK_SAME(a_no_push_full, i_clk, i_rst_n, r_v1 && i_stall, !res_valid, "push into full buffer")
    `CHK_SAME(a_plain_fields, i_clk, i_rst_n, o_valid && o_kind != K_COMMIT, o_bus_kind == 3'd0 && o_frame_id == 29'd0 && o_timestamp_ns == 64'd0, "descriptor fields on non-commit")
endmodule

// ===== src/pcfe_ram.sv =====
`timescale 1ns / 1ps
module pcfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/pcfe_parser.sv =====
`timescale 1ns / 1ps
module pcfe_parser
    import pcfe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic                i_action,
    input  logic [7:0]          i_in_byte,
    output logic                o_tbl_we,
    output logic [IFACE_AW-1:0] o_tbl_waddr,
    output logic [31:0]         o_tbl_wdata,
    output logic [IFACE_AW-1:0] o_tbl_raddr,
    input  logic [31:0]         i_tbl_rdata,
    output logic                o_res_valid,
    output t_result             o_res
);
    t_phase              r_phase, n_phase;
    logic [31:0]         r_pos, n_pos;
    logic [31:0]         r_btype, n_btype;
    logic [31:0]         r_blen, n_blen;
    logic [31:0]         r_tlen, n_tlen;
    logic [31:0]         r_link, n_link;
    logic [31:0]         r_pif, n_pif;
    logic [63:0]         r_time, n_time;
    logic [31:0]         r_cap, n_cap;
    logic [7:0]          r_head [HEAD_N];
    logic [7:0]          n_head [HEAD_N];
    logic                r_pend, n_pend;
    logic [IFACE_CW-1:0] r_count, n_count;
    logic                r_lookup, n_lookup;
    logic                r_hit, n_hit;

    // Decoded frame fields from the captured header bytes
    logic [6:0]  can_dlc;
    logic [3:0]  lin_len;
    logic [31:0] fr_tmp;
    logic [7:0]  fr_len;
    logic [10:0] fr_id;
    logic [31:0] win_st, win_cnt;

    always_comb begin
        can_dlc = (r_head[4] > 8'd64) ? 7'd64 : r_head[4][6:0];
        lin_len = (r_head[1][3:0] > 4'd8) ? 4'd8 : r_head[1][3:0];
        fr_tmp  = (r_cap >= 32'd7) ? (r_cap - 32'd7) : 32'd0;
        fr_len  = (fr_tmp > 32'd254) ? 8'd254 : fr_tmp[7:0];
        fr_id   = {r_head[3][3:0], r_head[2][7:1]};
        win_st  = '0;
        win_cnt = '0;
        if (r_link == LT_CAN) begin
            if (can_dlc != 7'd0 && r_cap >= 32'd8 + {25'd0, can_dlc}) begin
                win_st  = 32'd8;
                win_cnt = {25'd0, can_dlc};
            end
        end else if (r_link == LT_LIN) begin
            if (lin_len != 4'd0 && r_cap >= 32'd5 + {28'd0, lin_len}) begin
                win_st  = 32'd5;
                win_cnt = {28'd0, lin_len};
            end
        end else if (r_link == LT_ETH) begin
            win_cnt = r_cap;
        end else if (r_link == LT_FLEX) begin
            win_st  = 32'd7;
            win_cnt = {24'd0, fr_len};
        end
    end

    // Next state and results
    logic [31:0] body_len, pos_inc, q, cap_lim, pif_new, tlen_new, blen_new;
    logic        pend_now;
    t_result     desc;

    always_comb begin
        desc = '0;
        desc.kind = K_COMMIT;
        desc.timestamp_ns = r_time;
        if (r_link == LT_CAN) begin
            desc.bus_kind     = r_head[0][7] ? B_CANFD : B_CAN;
            desc.frame_id     = {r_head[0][4:0], r_head[1], r_head[2], r_head[3]};
            desc.frame_length = {1'b0, can_dlc};
        end else if (r_link == LT_LIN) begin
            desc.bus_kind     = B_LIN;
            desc.frame_id     = {21'd0, r_head[2]};
            desc.frame_length = {4'd0, lin_len};
        end else if (r_link == LT_ETH) begin
            desc.bus_kind     = B_ETH;
            desc.frame_id     = {13'd0, r_head[12], r_head[13]};
            desc.frame_length = (r_cap > 32'd255) ? 8'd255 : r_cap[7:0];
        end else begin
            desc.bus_kind     = B_FLEX;
            desc.frame_id     = {18'd0, fr_id};
            desc.frame_length = fr_len;
            desc.fr_channel   = r_head[0][7];
            desc.fr_cycle     = r_head[6][5:0];
            desc.fr_static    = (fr_id >= 11'd1) && (fr_id <= 11'd31);
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_btype  = r_btype;
        n_blen   = r_blen;
        n_tlen   = r_tlen;
        n_link   = r_link;
        n_pif    = r_pif;
        n_time   = r_time;
        n_cap    = r_cap;
        n_head   = r_head;
        n_pend   = r_pend;
        n_count  = r_count;
        n_lookup = 1'b0;
        n_hit    = r_hit;
        o_tbl_we    = 1'b0;
        o_tbl_waddr = r_count[IFACE_AW-1:0];
        o_tbl_wdata = r_link;
        o_res_valid = 1'b0;
        o_res       = '0;
        body_len = r_blen - 32'd12;
        pos_inc  = r_pos + 32'd1;
        q        = r_pos - 32'd20;
        cap_lim  = body_len - 32'd20;
        pif_new  = r_pif;
        pif_new[8*r_pos[1:0] +: 8] = i_in_byte;
        tlen_new = r_tlen;
        tlen_new[8*r_pos[1:0] +: 8] = i_in_byte;
        blen_new = r_blen;
        blen_new[8*r_pos[1:0] +: 8] = i_in_byte;
        pend_now = r_pend;
        o_tbl_raddr = pif_new[IFACE_AW-1:0];

        // Interface table read data arrives in the cycle after the request
        if (r_lookup) begin
            n_link = r_hit ? i_tbl_rdata : 32'd0;
        end

        if (i_take) begin
            if (i_action) begin
                // End of capture: cancel any open frame, clear the parse state (head bytes and hit flag are kept)
                if (r_pend) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = K_CANCEL;
                end
                n_phase  = PH_TYPE;
                n_pos    = '0;
                n_btype  = '0;
                n_blen   = '0;
                n_tlen   = '0;
                n_link   = '0;
                n_pif    = '0;
                n_time   = '0;
                n_cap    = '0;
                n_pend   = 1'b0;
                n_count  = '0;
                n_lookup = 1'b0;
            end else begin
                unique case (r_phase)
                    PH_TYPE: begin
                        n_btype[8*r_pos[1:0] +: 8] = i_in_byte;
                        if (r_pos[1:0] == 2'd3) begin
                            n_phase = PH_LEN;
                            n_pos   = '0;
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                    PH_LEN: begin
                        n_blen = blen_new;
                        if (r_pos[1:0] == 2'd3) begin
                            n_pos = '0;
                            if (blen_new < 32'd12) begin
                                n_phase     = PH_HALT;
                                o_res_valid = 1'b1;
                                o_res.kind  = K_ERROR;
                            end else begin
                                n_phase = (blen_new == 32'd12) ? PH_TRAIL : PH_BODY;
                            end
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                    PH_BODY: begin
                        if (r_btype == BT_IDB) begin
                            if (r_pos < 32'd4) begin
                                n_link[8*r_pos[1:0] +: 8] = i_in_byte;
                            end
                        end else if (r_btype == BT_EPB) begin
                            if (r_pos < 32'd4) begin
                                n_pif = pif_new;
                                if (r_pos[1:0] == 2'd3) begin
                                    n_lookup = 1'b1;
                                    n_hit    = pif_new < {{(32-IFACE_CW){1'b0}}, r_count};
                                end
                            end else if (r_pos < 32'd8) begin
                                n_time[32 + 8*r_pos[1:0] +: 8] = i_in_byte;
                            end else if (r_pos < 32'd12) begin
                                n_time[8*r_pos[1:0] +: 8] = i_in_byte;
                            end else if (r_pos < 32'd16) begin
                                n_cap[8*r_pos[1:0] +: 8] = i_in_byte;
                            end else if (r_pos < 32'd20) begin
                                if (r_pos == 32'd19) begin
                                    n_cap = (r_cap > cap_lim) ? cap_lim : r_cap;
                                    if ((r_link == LT_CAN && n_cap >= 32'd8) ||
                                        (r_link == LT_LIN && n_cap >= 32'd5) ||
                                        (r_link == LT_ETH && n_cap >= 32'd14)) begin
                                        n_pend = 1'b1;
                                    end
                                end
                            end else if (q < r_cap) begin
                                if (q < HEAD_N) begin
                                    n_head[q[3:0]] = i_in_byte;
                                end
                                if (q == 32'd0 && r_link == LT_FLEX && r_cap >= 32'd8 &&
                                    i_in_byte[6:0] == 7'd1) begin
                                    pend_now = 1'b1;
                                    n_pend   = 1'b1;
                                end
                                if (pend_now && q >= win_st && (q - win_st) < win_cnt) begin
                                    o_res_valid     = 1'b1;
                                    o_res.kind      = K_DATA;
                                    o_res.data_byte = i_in_byte;
                                end
                            end
                        end
                        n_pos = pos_inc;
                        if (pos_inc >= body_len) begin
                            n_phase = PH_TRAIL;
                            n_pos   = '0;
                        end
                    end
                    PH_TRAIL: begin
                        n_tlen = tlen_new;
                        if (r_pos[1:0] != 2'd3) begin
                            n_pos = pos_inc;
                        end else if (tlen_new != r_blen) begin
                            o_res_valid = 1'b1;
                            o_res.kind  = r_pend ? K_CANCEL : K_ERROR;
                            n_phase     = PH_HALT;
                            n_pend      = 1'b0;
                            n_pos       = '0;
                        end else begin
                            if (r_btype == BT_SHB) begin
                                n_count = '0;
                            end else if (r_btype == BT_IDB) begin
                                if (r_blen >= 32'd16 &&
                                    r_count < IFACE_CW'(IFACE_DEPTH)) begin
                                    o_tbl_we = 1'b1;
                                    n_count  = r_count + 1'b1;
                                end
                            end else if (r_btype == BT_EPB && r_pend) begin
                                o_res_valid = 1'b1;
                                o_res       = desc;
                            end
                            n_phase = PH_TYPE;
                            n_pos   = '0;
                            n_btype = '0;
                            n_blen  = '0;
                            n_tlen  = '0;
                            n_link  = '0;
                            n_pif   = '0;
                            n_time  = '0;
                            n_cap   = '0;
                            n_pend  = 1'b0;
                        end
                    end
                    PH_HALT: begin
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Control and field registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_pos    <= '0;
            r_btype  <= '0;
            r_blen   <= '0;
            r_tlen   <= '0;
            r_link   <= '0;
            r_pif    <= '0;
            r_time   <= '0;
            r_cap    <= '0;
            r_pend   <= 1'b0;
            r_count  <= '0;
            r_lookup <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_btype  <= n_btype;
            r_blen   <= n_blen;
            r_tlen   <= n_tlen;
            r_link   <= n_link;
            r_pif    <= n_pif;
            r_time   <= n_time;
            r_cap    <= n_cap;
            r_pend   <= n_pend;
            r_count  <= n_count;
            r_lookup <= n_lookup;
            r_hit    <= n_hit;
        end
    end

    // Payload head bytes
    always_ff @(posedge i_clk) begin
        r_head <= n_head;
    end
endmodule
